// File: rtl/bgc_pkg.sv
// Shared types, codes and sizes for the button gesture classifier.
// No dependencies; imported by button_gesture_classifier.
package bgc_pkg;

  localparam int BUTTONS     = 2;
  localparam int TIMER_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int MAX_RESULTS = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);

  localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // gesture codes
  localparam logic [1:0] GESTURE_SINGLE = 2'd0;
  localparam logic [1:0] GESTURE_DOUBLE = 2'd1;
  localparam logic [1:0] GESTURE_LONG   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DBL_WINDOW = CFG_IDX_BITS'(1);

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef struct packed {
    logic [1:0] gesture;
    logic       button;
    logic       last;
  } res_t;

  // Load value for a timer: saturate to the largest count it can hold.
  function automatic timer_t timer_load(input logic [CFG_BITS-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 > TIMER_MAX) begin
      return TIMER_MAX[TIMER_BITS-1:0];
    end
    return v32[TIMER_BITS-1:0];
  endfunction

endpackage

// File: rtl/button_gesture_classifier.sv
// Button gesture classifier: per-button long timers and double windows,
// results queued in a four-entry output FIFO. Depends on bgc_pkg.
//
// Flow: an accepted item is taken into the input register, processed there
//   once the queue has room, and its results are written into the FIFO.
// Throughput: one item per cycle while the queue has room for two results;
//   an item with two results takes two FIFO entries (FIFO room sets the pace).
// Reset (rst_n low, synchronous): timers cleared, queue emptied, registers
//   back to 1000 and 300 ticks.
module button_gesture_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic                              in_side,
  input  logic                              in_pressed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_gesture,
  output logic                              out_button,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bgc_pkg::CFG_BITS-1:0]      cfg_data
);
  import bgc_pkg::*;

  logic [CFG_BITS-1:0] long_ticks_r, win_ticks_r;

  logic               stg_valid_r, stg_op_r, stg_side_r, stg_pressed_r;
  logic               stg_fire;

  timer_t             long_count_r [BUTTONS];
  timer_t             long_count_nxt [BUTTONS];
  timer_t             win_count_r [BUTTONS];
  timer_t             win_count_nxt [BUTTONS];
  logic [BUTTONS-1:0] long_armed_r, long_armed_nxt;
  logic [BUTTONS-1:0] win_open_r, win_open_nxt;

  res_t               res [MAX_RESULTS];
  logic [1:0]         n_res;

  res_t               fifo_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] head_r, tail_r;
  logic [PTR_BITS:0]  cnt_r, cnt_nxt;
  logic               pop;

  assign cfg_ready = 1'b1;

  // Process only when the queue has room for the most results one item makes.
  assign stg_fire = stg_valid_r && (cnt_r <= (PTR_BITS+1)'(FIFO_DEPTH - MAX_RESULTS));
  assign in_ready = !stg_valid_r || stg_fire;

  assign out_valid   = (cnt_r != '0);
  assign pop         = out_valid && out_ready;
  assign out_gesture = fifo_r[head_r].gesture;
  assign out_button  = fifo_r[head_r].button;
  assign out_last    = fifo_r[head_r].last;

  always_comb begin
    long_count_nxt = long_count_r;
    win_count_nxt  = win_count_r;
    long_armed_nxt = long_armed_r;
    win_open_nxt   = win_open_r;
    n_res          = 2'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
    end
    if (stg_fire) begin
      if (stg_op_r == OP_TICK) begin
        for (int b = 0; b < BUTTONS; b++) begin
          if (win_open_r[b]) begin
            if (win_count_r[b] <= TIMER_BITS'(1)) begin
              win_open_nxt[b]  = 1'b0;
              win_count_nxt[b] = '0;
            end else begin
              win_count_nxt[b] = win_count_r[b] - TIMER_BITS'(1);
            end
          end
          if (long_armed_r[b]) begin
            if (long_count_r[b] <= TIMER_BITS'(1)) begin
              if (n_res < 2'(MAX_RESULTS)) begin
                res[n_res[0]].gesture = GESTURE_LONG;
                res[n_res[0]].button  = 1'(b);
                n_res                 = n_res + 2'd1;
                long_armed_nxt[b]     = 1'b0;
                long_count_nxt[b]     = '0;
              end else begin
                // no room this tick: report on the next one
                long_count_nxt[b] = TIMER_BITS'(1);
              end
            end else begin
              long_count_nxt[b] = long_count_r[b] - TIMER_BITS'(1);
            end
          end
        end
      end else begin
        for (int b = 0; b < BUTTONS; b++) begin
          if (b == int'(stg_side_r)) begin
            if (stg_pressed_r) begin
              long_armed_nxt[b] = 1'b1;
              long_count_nxt[b] = timer_load(long_ticks_r);
              res[0].button     = 1'(b);
              if (win_open_r[b]) begin
                win_open_nxt[b]  = 1'b0;
                win_count_nxt[b] = '0;
                res[0].gesture   = GESTURE_DOUBLE;
              end else begin
                res[0].gesture   = GESTURE_SINGLE;
              end
              n_res = 2'd1;
            end else begin
              long_armed_nxt[b] = 1'b0;
              long_count_nxt[b] = '0;
              win_open_nxt[b]   = 1'b1;
              win_count_nxt[b]  = timer_load(win_ticks_r);
            end
          end
        end
      end
    end
    if (n_res == 2'd1) begin
      res[0].last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign cnt_nxt = cnt_r + (PTR_BITS+1)'(n_res) - (PTR_BITS+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= CFG_BITS'(1000);
      win_ticks_r  <= CFG_BITS'(300);
      stg_valid_r  <= 1'b0;
      long_armed_r <= '0;
      win_open_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      for (int b = 0; b < BUTTONS; b++) begin
        long_count_r[b] <= '0;
        win_count_r[b]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LONG_PRESS) begin
          long_ticks_r <= cfg_data;
        end else if (cfg_index == CFG_DBL_WINDOW) begin
          win_ticks_r <= cfg_data;
        end
      end
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      long_count_r <= long_count_nxt;
      win_count_r  <= win_count_nxt;
      long_armed_r <= long_armed_nxt;
      win_open_r   <= win_open_nxt;
      tail_r       <= tail_r + PTR_BITS'(n_res);
      if (pop) begin
        head_r <= head_r + PTR_BITS'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Payload: input register and queue entries carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_op_r      <= in_opcode;
      stg_side_r    <= in_side;
      stg_pressed_r <= in_pressed;
    end
    if (n_res != 2'd0) begin
      fifo_r[tail_r] <= res[0];
    end
    if (n_res == 2'd2) begin
      fifo_r[tail_r + PTR_BITS'(1)] <= res[1];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_BITS+1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_stg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !stg_fire |=> stg_valid_r)
    else $error("held item lost from input register");

  a_armed_xor_open: assert property (@(posedge clk) disable iff (!rst_n)
    (long_armed_r & win_open_r) == '0)
    else $error("long timer and double window both running on one button");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(head_r))
    else $error("stalled result dropped");
`endif

endmodule

// File: sim/bgc_gesture_checker.sv
// Result checker for button_gesture_classifier: follows register writes and
// accepted items, predicts every gesture and compares it with the result port.
// Depends on bgc_pkg.
module bgc_gesture_checker
  import bgc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_opcode,
  input  logic                    in_side,
  input  logic                    in_pressed,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              out_gesture,
  input  logic                    out_button,
  input  logic                    out_last,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output int                      mismatches,
  output int                      outstanding
);

  localparam logic [CFG_BITS-1:0] HOLD_TICKS_RESET   = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] WINDOW_TICKS_RESET = CFG_BITS'(300);

  logic [CFG_BITS-1:0] hold_ticks;
  logic [CFG_BITS-1:0] window_ticks;
  timer_t              hold_left [BUTTONS];
  logic                hold_run  [BUTTONS];
  timer_t              win_left  [BUTTONS];
  logic                win_open  [BUTTONS];
  res_t                gesture_q [$];
  int                  errors = 0;

  function automatic timer_t start_count(input logic [CFG_BITS-1:0] ticks);
    start_count = (32'(ticks) > TIMER_MAX) ? timer_t'(TIMER_MAX) : timer_t'(ticks);
  endfunction

  // Update the timers for one item and queue the gestures it gives.
  task automatic classify_item(input logic op, input logic side, input logic pressed);
    res_t made [MAX_RESULTS];
    int   n;
    int   b;
    n = 0;
    if (op == OP_TICK) begin
      for (b = 0; b < BUTTONS; b++) begin
        if (win_open[b]) begin
          if (win_left[b] <= 1) begin
            win_open[b] = 1'b0;
            win_left[b] = '0;
          end else begin
            win_left[b] = win_left[b] - 1'b1;
          end
        end
        if (hold_run[b]) begin
          if (hold_left[b] <= 1) begin
            if (n < MAX_RESULTS) begin
              made[n].gesture = GESTURE_LONG;
              made[n].button  = b[0];
              n++;
              hold_run[b]  = 1'b0;
              hold_left[b] = '0;
            end else begin
              // no room this tick: hold at one so it fires on the next
              hold_left[b] = timer_t'(1);
            end
          end else begin
            hold_left[b] = hold_left[b] - 1'b1;
          end
        end
      end
    end else if (int'(side) < BUTTONS) begin
      b = int'(side);
      if (pressed) begin
        hold_run[b]     = 1'b1;
        hold_left[b]    = start_count(hold_ticks);
        made[0].button  = side;
        made[0].gesture = win_open[b] ? GESTURE_DOUBLE : GESTURE_SINGLE;
        win_open[b]     = 1'b0;
        win_left[b]     = '0;
        n = 1;
      end else begin
        hold_run[b]  = 1'b0;
        hold_left[b] = '0;
        win_open[b]  = 1'b1;
        win_left[b]  = start_count(window_ticks);
      end
    end
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      gesture_q.push_back(made[i]);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      hold_ticks   = HOLD_TICKS_RESET;
      window_ticks = WINDOW_TICKS_RESET;
      for (int b = 0; b < BUTTONS; b++) begin
        hold_left[b] = '0;
        hold_run[b]  = 1'b0;
        win_left[b]  = '0;
        win_open[b]  = 1'b0;
      end
      gesture_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (gesture_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: got gesture %0d button %0d last %0d",
                   $time, out_gesture, out_button, out_last);
        end else begin
          want = gesture_q.pop_front();
          if (out_gesture !== want.gesture) begin
            errors++;
            $display("%0t: gesture expected %0d, got %0d", $time, want.gesture, out_gesture);
          end
          if (out_button !== want.button) begin
            errors++;
            $display("%0t: button expected %0d, got %0d", $time, want.button, out_button);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last expected %0d, got %0d", $time, want.last, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LONG_PRESS) begin
          hold_ticks = cfg_data;
        end else if (cfg_index == CFG_DBL_WINDOW) begin
          window_ticks = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        classify_item(in_opcode, in_side, in_pressed);
      end
    end
    mismatches  <= errors;
    outstanding <= gesture_q.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the button_gesture_classifier bench: clock, reset, item and register
// stimulus, result-side stalls and the verdict. Depends on bgc_pkg,
// button_gesture_classifier and bgc_gesture_checker.
module testbench;
  import bgc_pkg::*;

  localparam int GAP_MAX       = 9;
  localparam int DRAIN         = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 165;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = CFG_IDX_BITS'(3);

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic                    in_opcode  = OP_TICK;
  logic                    in_side    = 1'b0;
  logic                    in_pressed = 1'b0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [1:0]              out_gesture;
  logic                    out_button;
  logic                    out_last;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index  = CFG_LONG_PRESS;
  logic [CFG_BITS-1:0]     cfg_data   = '0;

  int   mismatches;
  int   outstanding;
  int   stall_cycles = 0;
  logic send_quiet   = 1'b0;
  logic held [BUTTONS];

  button_gesture_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_side     (in_side),
    .in_pressed  (in_pressed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_gesture (out_gesture),
    .out_button  (out_button),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  bgc_gesture_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_side     (in_side),
    .in_pressed  (in_pressed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_gesture (out_gesture),
    .out_button  (out_button),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Result side: stall a random number of cycles before each item, with quiet spells.
  initial begin
    int   gap;
    int   served;
    logic quiet;
    served = 0;
    quiet  = 1'b0;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      served++;
      if (served % 40 == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Offer one item; leave valid high on return so a back-to-back item keeps it up.
  task automatic send_item(input logic op, input logic side, input logic pressed);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode  <= op;
    in_side    <= side;
    in_pressed <= pressed;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                           input logic [CFG_BITS-1:0] data);
    cfg_index <= index;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Wait for every expected result, then for any release or tick still in flight.
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic run_random_phase(input int phase);
    logic [CFG_BITS-1:0] hold_cfg;
    logic [CFG_BITS-1:0] window_cfg;
    int                  tick_weight;
    int                  pick;
    logic                s;
    hold_cfg   = CFG_BITS'($urandom_range(1, 12));
    window_cfg = CFG_BITS'($urandom_range(1, 12));
    if (phase == 3) begin
      hold_cfg = '1;
    end
    if (phase == 6) begin
      window_cfg = '1;
    end
    if (phase == 8) begin
      hold_cfg   = CFG_BITS'($urandom_range(1, 65535));
      window_cfg = CFG_BITS'($urandom_range(1, 65535));
    end
    write_reg(CFG_LONG_PRESS, hold_cfg);
    write_reg(CFG_DBL_WINDOW, window_cfg);
    if (phase == 2) begin
      write_reg(CFG_SPARE_LO, CFG_BITS'($urandom));
      write_reg(CFG_SPARE_HI, CFG_BITS'($urandom));
    end
    cfg_valid <= 1'b0;
    send_quiet  = ($urandom_range(0, 3) == 0);
    tick_weight = $urandom_range(25, 70);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      s    = 1'($urandom_range(0, 1));
      if (pick < tick_weight) begin
        send_item(OP_TICK, s, 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        // alternate press and release per button
        send_item(OP_EDGE, s, !held[s]);
        held[s] = !held[s];
      end else begin
        held[s] = 1'($urandom_range(0, 1));
        send_item(OP_EDGE, s, held[s]);
      end
    end
    in_valid <= 1'b0;
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: single, double, repeated press and release
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b1, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b0);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b0);
    send_item(OP_EDGE, 1'b1, 1'b0);
    in_valid <= 1'b0;
    settle();

    // one-tick timers: both buttons expire on the same tick
    write_reg(CFG_LONG_PRESS, CFG_BITS'(1));
    write_reg(CFG_DBL_WINDOW, CFG_BITS'(1));
    cfg_valid <= 1'b0;
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b1, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_TICK, 1'b1, 1'b0);
    in_valid <= 1'b0;
    settle();

    // largest counts
    write_reg(CFG_LONG_PRESS, '1);
    write_reg(CFG_DBL_WINDOW, '1);
    cfg_valid <= 1'b0;
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b1, 1'b0);
    in_valid <= 1'b0;
    settle();

    held[0] = 1'b1;
    held[1] = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      run_random_phase(p);
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
